// ===== rtl/rotation_matrix_to_quaternion_defines.svh =====
// Assertion macros used by the checker file.
`ifndef ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH
// Implication checked on every rising clock edge, disabled while in reset.
`define RMQ_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// Next-cycle implication checked on every rising clock edge, disabled while in reset.
`define RMQ_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

// ===== rtl/rmq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared constants, widths and types of the rotation-to-quaternion pipeline.
// ----------------------------------------------------------------------------
package rmq_pkg;
    localparam int unsigned DataW = 32;
    localparam int unsigned FracW = 30;
    localparam int unsigned MagW  = 31;
    localparam int unsigned SumW  = 34;
    localparam int unsigned SqW   = 64;
    localparam int unsigned LenW  = 32;
    localparam int unsigned NumW  = MagW + FracW;
    localparam int unsigned QuoW  = 31;
    localparam int unsigned InW   = 9 * DataW;
    localparam int unsigned OutW  = 4 * DataW;

    typedef logic [InW-1:0]  t_in_data;
    typedef logic [OutW-1:0] t_out_data;

    typedef struct packed {
        logic            degen;
        logic [3:0]      neg;
        logic [MagW-1:0] mag0;
        logic [MagW-1:0] mag1;
        logic [MagW-1:0] mag2;
        logic [MagW-1:0] mag3;
    } t_norm_item;
endpackage

// ===== rtl/rmq_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_front
// Branch selection, radicand forming and block scaling, three stages.
// ----------------------------------------------------------------------------
module rmq_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  rmq_pkg::t_in_data    i_data,
    output logic                 o_valid,
    output rmq_pkg::t_norm_item  o_item
);
    import rmq_pkg::*;

    logic signed [DataW-1:0] m [9];
    logic signed [SumW-1:0]  n_v [4];
    logic signed [SumW-1:0]  r_v [4];
    logic signed [SumW-1:0]  tr, one, ra, rb, rc, rd;
    logic                    r_v1, r_v2, r_v3;
    logic                    n_deg, r_deg1, r_deg2;
    logic [SumW-1:0]         n_mag [4];
    logic [SumW-1:0]         r_mag [4];
    logic [3:0]              n_neg, r_neg2;
    logic [SumW-1:0]         big;
    logic [5:0]              bl;
    logic [SumW-1:0]         sc [4];
    t_norm_item              r_item;

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            m[i] = i_data[i*DataW +: DataW];
        end
        one = SumW'(1) <<< FracW;
        tr  = SumW'(m[0]) + SumW'(m[4]) + SumW'(m[8]);
        ra  = tr + one;
        rb  = one + SumW'(m[0]) - SumW'(m[4]) - SumW'(m[8]);
        rc  = one + SumW'(m[4]) - SumW'(m[0]) - SumW'(m[8]);
        rd  = one + SumW'(m[8]) - SumW'(m[0]) - SumW'(m[4]);
        if (tr > 0) begin
            n_v[0] = ra;
            n_v[1] = SumW'(m[7]) - SumW'(m[5]);
            n_v[2] = SumW'(m[2]) - SumW'(m[6]);
            n_v[3] = SumW'(m[3]) - SumW'(m[1]);
            n_deg  = 1'b0;
        end else if (m[0] > m[4] && m[0] > m[8]) begin
            n_v[0] = SumW'(m[7]) - SumW'(m[5]);
            n_v[1] = rb;
            n_v[2] = SumW'(m[1]) + SumW'(m[3]);
            n_v[3] = SumW'(m[2]) + SumW'(m[6]);
            n_deg  = (rb <= 0);
        end else if (m[4] > m[8]) begin
            n_v[0] = SumW'(m[2]) - SumW'(m[6]);
            n_v[1] = SumW'(m[1]) + SumW'(m[3]);
            n_v[2] = rc;
            n_v[3] = SumW'(m[5]) + SumW'(m[7]);
            n_deg  = (rc <= 0);
        end else begin
            n_v[0] = SumW'(m[3]) - SumW'(m[1]);
            n_v[1] = SumW'(m[2]) + SumW'(m[6]);
            n_v[2] = SumW'(m[5]) + SumW'(m[7]);
            n_v[3] = rd;
            n_deg  = (rd <= 0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v    <= n_v;
            r_deg1 <= n_deg;
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_neg[i] = r_v[i][SumW-1];
            n_mag[i] = n_neg[i] ? SumW'(-r_v[i]) : SumW'(r_v[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag  <= n_mag;
            r_neg2 <= n_neg;
            r_deg2 <= r_deg1;
        end
    end

    always_comb begin
        big = '0;
        for (int i = 0; i < 4; i++) begin
            big = big | r_mag[i];
        end
        bl = '0;
        for (int b = 0; b < SumW; b++) begin
            if (big[b]) begin
                bl = 6'(b + 1);
            end
        end
        for (int i = 0; i < 4; i++) begin
            if (bl > 6'(MagW)) begin
                sc[i] = r_mag[i] >> (bl - 6'(MagW));
            end else begin
                sc[i] = r_mag[i] << (6'(MagW) - bl);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item.degen <= r_deg2;
            r_item.neg   <= r_neg2;
            r_item.mag0  <= sc[0][MagW-1:0];
            r_item.mag1  <= sc[1][MagW-1:0];
            r_item.mag2  <= sc[2][MagW-1:0];
            r_item.mag3  <= sc[3][MagW-1:0];
        end
    end

    assign o_valid = r_v3;
    assign o_item  = r_item;
endmodule

// ===== rtl/rmq_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_sqrt
// Sum of squares and a pipelined integer square root, one result bit a stage.
// ----------------------------------------------------------------------------
module rmq_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  rmq_pkg::t_norm_item         i_item,
    output logic                        o_valid,
    output rmq_pkg::t_norm_item         o_item,
    output logic [rmq_pkg::LenW-1:0]    o_len
);
    import rmq_pkg::*;

    localparam int unsigned Steps = LenW;

    logic [2*MagW-1:0] n_sq [4];
    logic [2*MagW-1:0] r_sq [4];
    logic              r_vs;
    t_norm_item        r_its;
    logic              r_vp [Steps+1];
    t_norm_item        r_ip [Steps+1];
    logic [SqW-1:0]    r_rem [Steps+1];
    logic [LenW-1:0]   r_root [Steps+1];
    logic [SqW-1:0]    n_rem [Steps];
    logic [LenW-1:0]   n_root [Steps];

    always_comb begin
        n_sq[0] = (2*MagW)'(i_item.mag0) * (2*MagW)'(i_item.mag0);
        n_sq[1] = (2*MagW)'(i_item.mag1) * (2*MagW)'(i_item.mag1);
        n_sq[2] = (2*MagW)'(i_item.mag2) * (2*MagW)'(i_item.mag2);
        n_sq[3] = (2*MagW)'(i_item.mag3) * (2*MagW)'(i_item.mag3);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vs <= 1'b0;
        end else if (i_en) begin
            r_vs <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq  <= n_sq;
            r_its <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp[0] <= 1'b0;
        end else if (i_en) begin
            r_vp[0] <= r_vs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ip[0]   <= r_its;
            r_rem[0]  <= SqW'(r_sq[0]) + SqW'(r_sq[1]) + SqW'(r_sq[2]) + SqW'(r_sq[3]);
            r_root[0] <= '0;
        end
    end

    always_comb begin
        for (int k = 0; k < Steps; k++) begin
            logic [LenW-1:0] trial;
            logic [SqW-1:0]  cand;
            trial = r_root[k] | (LenW'(1) << (Steps - 1 - k));
            cand  = SqW'(trial) * SqW'(trial);
            if (cand <= r_rem[k]) begin
                n_root[k] = trial;
            end else begin
                n_root[k] = r_root[k];
            end
            n_rem[k] = r_rem[k];
        end
    end

    for (genvar k = 0; k < Steps; k++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vp[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vp[k+1] <= r_vp[k];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ip[k+1]   <= r_ip[k];
                r_rem[k+1]  <= n_rem[k];
                r_root[k+1] <= n_root[k];
            end
        end
    end

    assign o_valid = r_vp[Steps];
    assign o_item  = r_ip[Steps];
    assign o_len   = r_root[Steps];
endmodule

// ===== rtl/rmq_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_div
// Four lanes of restoring division, one quotient bit a stage, with rounding.
// ----------------------------------------------------------------------------
module rmq_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  rmq_pkg::t_norm_item         i_item,
    input  logic [rmq_pkg::LenW-1:0]    i_len,
    output logic                        o_valid,
    output rmq_pkg::t_out_data          o_data,
    output logic                        o_degen
);
    import rmq_pkg::*;

    localparam int unsigned Steps = QuoW;
    localparam int unsigned RemW  = LenW + 1;

    logic              r_vp [Steps+1];
    logic              r_dg [Steps+1];
    logic [3:0]        r_ng [Steps+1];
    logic [LenW-1:0]   r_ln [Steps+1];
    logic [NumW:0]     r_num [Steps+1][4];
    logic [RemW-1:0]   r_rem [Steps+1][4];
    logic [QuoW-1:0]   r_quo [Steps+1][4];
    logic [RemW-1:0]   n_rem [Steps][4];
    logic [QuoW-1:0]   n_quo [Steps][4];
    logic [MagW-1:0]   in_mag [4];
    logic [NumW:0]     num0 [4];
    logic              r_vo;
    t_out_data         r_out;
    logic              r_dgo;

    always_comb begin
        in_mag[0] = i_item.mag0;
        in_mag[1] = i_item.mag1;
        in_mag[2] = i_item.mag2;
        in_mag[3] = i_item.mag3;
        for (int i = 0; i < 4; i++) begin
            num0[i] = ((NumW+1)'(in_mag[i]) << FracW) + (NumW+1)'(i_len >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp[0] <= 1'b0;
        end else if (i_en) begin
            r_vp[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dg[0] <= i_item.degen;
            r_ng[0] <= i_item.neg;
            r_ln[0] <= i_len;
            for (int i = 0; i < 4; i++) begin
                r_num[0][i] <= num0[i];
                r_rem[0][i] <= RemW'(num0[i] >> Steps);
                r_quo[0][i] <= '0;
            end
        end
    end

    always_comb begin
        for (int k = 0; k < Steps; k++) begin
            for (int i = 0; i < 4; i++) begin
                logic [RemW-1:0] sh;
                sh = {r_rem[k][i][RemW-2:0], r_num[k][i][Steps-1-k]};
                if (sh >= RemW'(r_ln[k])) begin
                    n_rem[k][i] = sh - RemW'(r_ln[k]);
                    n_quo[k][i] = {r_quo[k][i][QuoW-2:0], 1'b1};
                end else begin
                    n_rem[k][i] = sh;
                    n_quo[k][i] = {r_quo[k][i][QuoW-2:0], 1'b0};
                end
            end
        end
    end

    for (genvar k = 0; k < Steps; k++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vp[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vp[k+1] <= r_vp[k];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dg[k+1]  <= r_dg[k];
                r_ng[k+1]  <= r_ng[k];
                r_ln[k+1]  <= r_ln[k];
                r_num[k+1] <= r_num[k];
                r_rem[k+1] <= n_rem[k];
                r_quo[k+1] <= n_quo[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (i_en) begin
            r_vo <= r_vp[Steps];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dgo <= r_dg[Steps];
            for (int i = 0; i < 4; i++) begin
                if (r_dg[Steps]) begin
                    r_out[i*DataW +: DataW] <= (i == 0) ? DataW'(1) << FracW : '0;
                end else if (r_ng[Steps][i]) begin
                    r_out[i*DataW +: DataW] <= DataW'(-DataW'(r_quo[Steps][i]));
                end else begin
                    r_out[i*DataW +: DataW] <= DataW'(r_quo[Steps][i]);
                end
            end
        end
    end

    assign o_valid = r_vo;
    assign o_data  = r_out;
    assign o_degen = r_dgo;
endmodule

// ===== rtl/rotation_matrix_to_quaternion.sv =====
`timescale 1ns / 1ps
// Throughput: one matrix per cycle unless the output stalls; the square root
// and division are unrolled one bit per stage so a new item enters each cycle.
// A stall at the output holds every stage; nothing is lost or repeated.
// Reset (synchronous, active low) clears all valid bits.
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Rotation matrix to unit quaternion by Shepperd's method, fully pipelined.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22 from bit 0 up
    input  rmq_pkg::t_in_data     s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // quat_w, quat_x, quat_y, quat_z from bit 0 up
    output rmq_pkg::t_out_data    m_axis_tdata,
    // degenerate
    output logic                  m_axis_tuser
);
    import rmq_pkg::*;

    logic              en;
    logic              fv, sv;
    t_norm_item        fi, si;
    logic [LenW-1:0]   sl;

    assign en            = m_axis_tready || !m_axis_tvalid;
    assign s_axis_tready = en;

    rmq_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(s_axis_tvalid), .i_data(s_axis_tdata),
        .o_valid(fv), .o_item(fi)
    );

    rmq_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(fv), .i_item(fi),
        .o_valid(sv), .o_item(si), .o_len(sl)
    );

    rmq_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(sv), .i_item(si), .i_len(sl),
        .o_valid(m_axis_tvalid), .o_data(m_axis_tdata), .o_degen(m_axis_tuser)
    );
endmodule

// ===== rtl/rmq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_checker
// Port-level checks of the rotation-to-quaternion block.
// ----------------------------------------------------------------------------
`include "rotation_matrix_to_quaternion_defines.svh"
module rmq_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input rmq_pkg::t_out_data    m_axis_tdata,
    input logic                  m_axis_tuser
);
    `RMQ_ASSERT_IMP(a_degen_identity, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser,
        m_axis_tdata == 128'h0000_0000_0000_0000_0000_0000_4000_0000, "degenerate not identity")
    `RMQ_ASSERT_IMP(a_ready_when_free, i_clk, i_rst_n, !m_axis_tvalid, s_axis_tready,
        "input stalled while output empty")
    `RMQ_ASSERT_NXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "stalled output changed")
endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (.*);
